// ===== src/assert_macros.svh =====
// Assertion macros shared by the matrix core RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising clock edge out of reset.
`define M3AS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define M3AS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/m3as_pkg.sv =====
// Package for the matrix add / subtract / multiply core.
// Holds the matrix size, element types, mode codes and operation codes.
`timescale 1ns / 1ps

package m3as_pkg;

	// Matrix dimension; supported range is 2 to 8.
	localparam int DIM    = 3;
	localparam int CELLS  = DIM * DIM;
	localparam int IDX_W  = $clog2(CELLS);
	localparam int DIM_W  = $clog2(DIM);
	localparam int ELEM_W = 32;
	localparam int MODE_W = 2;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [DIM_W-1:0]         dim_idx_t;
	typedef logic [MODE_W-1:0]        mode_t;

	// Register codes of operation_mode; the unused code behaves as the product.
	localparam mode_t MODE_ADD = 2'd0;
	localparam mode_t MODE_SUB = 2'd1;
	localparam mode_t MODE_MUL = 2'd2;

	// Operation carried out by the shared arithmetic unit.
	typedef enum logic [1:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL
	} op_t;

	// Control that travels with one read of the element stores.
	typedef struct packed {
		logic vld;
		logic first;
		op_t  op;
	} alu_ctl_t;

endpackage

// ===== src/m3as_if.sv =====
// Channel interfaces of the matrix core: element pairs in, results out, mode writes.
// Depends on m3as_pkg for the payload types.
`timescale 1ns / 1ps

interface m3as_in_if;
	logic              valid;
	logic              ready;
	m3as_pkg::elem_t   a_element;
	m3as_pkg::elem_t   b_element;

	modport source (output valid, output a_element, output b_element, input ready);
	modport sink (input valid, input a_element, input b_element, output ready);
endinterface

interface m3as_out_if;
	logic              valid;
	logic              ready;
	m3as_pkg::elem_t   result_element;
	logic              last_element;

	modport source (output valid, output result_element, output last_element, input ready);
	modport sink (input valid, input result_element, input last_element, output ready);
endinterface

interface m3as_cfg_if;
	logic              valid;
	logic              ready;
	m3as_pkg::mode_t   data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/m3as_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for both element stores of the matrix core.
`timescale 1ns / 1ps

module m3as_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 9
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/m3as_alu.sv =====
// Shared arithmetic unit: one add, subtract or 32x32 multiply per cycle plus an accumulator.
// Depends on m3as_pkg; its operands come from the registered RAM read ports.
`timescale 1ns / 1ps

module m3as_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  m3as_pkg::alu_ctl_t ctl,
	input  m3as_pkg::elem_t    a_data,
	input  m3as_pkg::elem_t    b_data,
	output m3as_pkg::elem_t    acc,
	output logic               busy
);

	import m3as_pkg::*;

	alu_ctl_t ctl_s1;
	logic     vld_s2;
	logic     first_s2;
	elem_t    res_s2;
	elem_t    acc_q;
	elem_t    res_d;

	// One operation on the freshly read pair; all results wrap to 32 bits.
	always_comb begin
		unique case (ctl_s1.op)
			OP_ADD:  res_d = a_data + b_data;
			OP_SUB:  res_d = a_data - b_data;
			OP_MUL:  res_d = a_data * b_data;
			default: res_d = a_data + b_data;
		endcase
	end

	// Control is registered to line up with the RAM read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			vld_s2   <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			ctl_s1   <= ctl;
			vld_s2   <= ctl_s1.vld;
			first_s2 <= ctl_s1.first;
		end
	end

	// Operation result and accumulator; the first term of a cell restarts the sum.
	always_ff @(posedge clk) begin
		if (ctl_s1.vld) begin
			res_s2 <= res_d;
		end
		if (vld_s2) begin
			acc_q <= first_s2 ? res_s2 : acc_q + res_s2;
		end
	end

	assign acc  = acc_q;
	assign busy = ctl_s1.vld | vld_s2;

endmodule

// ===== src/matrix3x3_add_sub_mul_core.sv =====
// Matrix core: sum, difference or product of two DIM x DIM signed 32-bit matrices.
// Loading takes one pair per cycle in ST_LOAD (DIM*DIM pairs per set, 9 at DIM = 3).
// Each result is built from one read pair per term (one term for add/subtract, DIM for
// the product) via each store's single read port into the shared multiply-accumulate unit.
// The block does not take pairs while results are computed; one result may wait in
// the output register. Reset (arst_n low) clears mode, counters and state; no clearing pass.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module matrix3x3_add_sub_mul_core (
	input  logic       clk,
	input  logic       arst_n,
	m3as_cfg_if.sink   cfg,
	m3as_in_if.sink    in_ch,
	m3as_out_if.source out_ch
);

	import m3as_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	localparam idx_t     LAST_IDX = idx_t'(CELLS - 1);
	localparam dim_idx_t LAST_DIM = dim_idx_t'(DIM - 1);

	state_t   state_q;
	mode_t    mode_q;
	op_t      op_q;
	idx_t     load_count_q;
	dim_idx_t row_q;
	dim_idx_t col_q;
	dim_idx_t k_q;
	logic     out_valid_q;
	elem_t    out_result_q;
	logic     out_last_q;

	logic     in_xfer;
	logic     out_free;
	logic     issue;
	logic     emit;
	logic     last_term;
	logic     last_cell;
	idx_t     a_addr;
	idx_t     b_addr;
	elem_t    a_rdata;
	elem_t    b_rdata;
	elem_t    acc;
	logic     alu_busy;
	alu_ctl_t alu_ctl;

	// Mode register; the port never stalls.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ADD;
		end else if (cfg.valid) begin
			mode_q <= cfg.data;
		end
	end

	// Handshake and sequencing conditions.
	assign in_ch.ready = (state_q == ST_LOAD);
	assign in_xfer     = in_ch.valid & in_ch.ready;
	assign out_free    = ~out_valid_q | out_ch.ready;
	assign issue       = (state_q == ST_ISSUE);
	assign last_term   = (op_q != OP_MUL) || (k_q == LAST_DIM);
	assign last_cell   = (row_q == LAST_DIM) && (col_q == LAST_DIM);

	// A finished cell moves into the output register once the register is free.
	assign emit        = (state_q == ST_DRAIN) && !alu_busy && out_free;

	// Store read addresses: row-major element for add/subtract, row by column for product.
	always_comb begin
		if (op_q == OP_MUL) begin
			a_addr = idx_t'(int'(row_q) * DIM + int'(k_q));
			b_addr = idx_t'(int'(k_q) * DIM + int'(col_q));
		end else begin
			a_addr = idx_t'(int'(row_q) * DIM + int'(col_q));
			b_addr = a_addr;
		end
	end

	assign alu_ctl.vld   = issue;
	assign alu_ctl.first = (k_q == '0);
	assign alu_ctl.op    = op_q;

	m3as_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(CELLS)
	) u_left_store (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (load_count_q),
		.wdata (in_ch.a_element),
		.re    (issue),
		.raddr (a_addr),
		.rdata (a_rdata)
	);

	m3as_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(CELLS)
	) u_right_store (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (load_count_q),
		.wdata (in_ch.b_element),
		.re    (issue),
		.raddr (b_addr),
		.rdata (b_rdata)
	);

	m3as_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (alu_ctl),
		.a_data (a_rdata),
		.b_data (b_rdata),
		.acc    (acc),
		.busy   (alu_busy)
	);

	// Sequencer: load pairs, issue reads for one cell, drain and emit, repeat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			op_q         <= OP_ADD;
			load_count_q <= '0;
			row_q        <= '0;
			col_q        <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
			out_result_q <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= emit | (out_valid_q & ~out_ch.ready);
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (load_count_q == LAST_IDX) begin
							load_count_q <= '0;
							row_q        <= '0;
							col_q        <= '0;
							k_q          <= '0;
							state_q      <= ST_ISSUE;
							unique case (mode_q)
								MODE_ADD: op_q <= OP_ADD;
								MODE_SUB: op_q <= OP_SUB;
								default:  op_q <= OP_MUL;
							endcase
						end else begin
							load_count_q <= load_count_q + 1'b1;
						end
					end
				end
				ST_ISSUE: begin
					if (last_term) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (emit) begin
						out_result_q <= acc;
						out_last_q   <= last_cell;
						if (last_cell) begin
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_ISSUE;
							if (col_q == LAST_DIM) begin
								col_q <= '0;
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.result_element = out_result_q;
	assign out_ch.last_element   = out_last_q;

	// Pairs are never stored while the arithmetic unit still works on a set.
	`M3AS_ASSERT_ALWAYS(a_load_idle, !(in_ch.ready && alu_busy), "pair taken while unit busy")
	// A partial load count exists only in the load state.
	`M3AS_ASSERT_ALWAYS(a_count_load, load_count_q == '0 || state_q == ST_LOAD, "count outside load")
	// The completing pair starts the first cell of the result.
	`M3AS_ASSERT_NEXT(a_set_start, in_xfer && load_count_q == LAST_IDX,
		state_q == ST_ISSUE && row_q == '0 && col_q == '0, "set did not start at cell zero")

endmodule
